// File: design/nearest_point_velocity_lookup_macros.svh
// Assertion macros for the nearest-point velocity lookup.
// Used by the top level; expects clk and rst in the enclosing scope.
`ifndef NEAREST_POINT_VELOCITY_LOOKUP_MACROS_SVH
`define NEAREST_POINT_VELOCITY_LOOKUP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NPV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npv assertion failed");

// Next-cycle implication, checked outside reset.
`define NPV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npv assertion failed");

`endif

// File: design/npv_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the nearest-point velocity lookup.
// No dependencies.
package npv_pkg;

  localparam int NPV_MAX_POINTS = 1024;
  localparam int NPV_IDX_W      = 10;
  localparam int NPV_CNT_W      = 11;
  localparam int NPV_WORD_W     = 32;
  localparam int NPV_SUM_W      = 65;
  localparam int NPV_RAD_W      = 66;
  localparam int NPV_ROOT_W     = 33;
  localparam int NPV_DIST_W     = 34;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SQRT,
    S_VEL,
    S_LOAD,
    S_EMPTY
  } npv_state_t;

endpackage

// File: design/npv_store.sv
`timescale 1ns / 1ps
// Point table: position memory and velocity memory, one write and one read port.
// Depends on npv_pkg.
module npv_store import npv_pkg::*; #(
  parameter int DEPTH = NPV_MAX_POINTS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [2*NPV_WORD_W-1:0]   wpos,
  input  logic [3*NPV_WORD_W-1:0]   wvel,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [2*NPV_WORD_W-1:0]   rpos,
  output logic [3*NPV_WORD_W-1:0]   rvel
);

  logic [2*NPV_WORD_W-1:0] pos_mem [DEPTH];
  logic [3*NPV_WORD_W-1:0] vel_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[waddr] <= wpos;
      vel_mem[waddr] <= wvel;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rpos <= pos_mem[raddr];
      rvel <= vel_mem[raddr];
    end
  end

endmodule

// File: design/npv_dist.sv
`timescale 1ns / 1ps
// Squared planar distance pipeline: absolute difference, squares, sum.
// Depends on npv_pkg.
module npv_dist import npv_pkg::*; #(
  parameter int AW = $clog2(NPV_MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic [AW-1:0]                in_idx,
  input  logic signed [NPV_WORD_W-1:0] qx,
  input  logic signed [NPV_WORD_W-1:0] qz,
  input  logic signed [NPV_WORD_W-1:0] px,
  input  logic signed [NPV_WORD_W-1:0] pz,
  output logic                         out_vld,
  output logic [AW-1:0]                out_idx,
  output logic [NPV_SUM_W-1:0]         sum,
  output logic                         busy
);

  logic                        v1, v2;
  logic [AW-1:0]               idx1, idx2;
  logic [NPV_WORD_W-1:0]       ax, az;
  logic [2*NPV_WORD_W-1:0]     sx, sz;
  logic signed [NPV_WORD_W:0]  dx, dz;

  // A difference of two 32-bit signed values fits in 33 bits; its magnitude in 32.
  always_comb begin
    dx = {qx[NPV_WORD_W-1], qx} - {px[NPV_WORD_W-1], px};
    dz = {qz[NPV_WORD_W-1], qz} - {pz[NPV_WORD_W-1], pz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx1    <= in_idx;
    ax      <= dx[NPV_WORD_W] ? NPV_WORD_W'(-dx) : NPV_WORD_W'(dx);
    az      <= dz[NPV_WORD_W] ? NPV_WORD_W'(-dz) : NPV_WORD_W'(dz);
    idx2    <= idx1;
    sx      <= ax * ax;
    sz      <= az * az;
    out_idx <= idx2;
    sum     <= {1'b0, sx} + {1'b0, sz};
  end

  assign busy = v1 | v2 | out_vld;

endmodule

// File: design/npv_sqrt.sv
`timescale 1ns / 1ps
// Iterative integer square root, one root bit per cycle, floor result.
// Depends on npv_pkg.
module npv_sqrt import npv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NPV_RAD_W-1:0]  radicand,
  output logic                  done,
  output logic [NPV_ROOT_W-1:0] root
);

  logic                   busy;
  logic [5:0]             steps;
  logic [NPV_RAD_W-1:0]   rad;
  logic [NPV_ROOT_W+1:0]  rem;
  logic [NPV_ROOT_W+3:0]  rem_w, trial;
  logic                   ge;

  always_comb begin
    rem_w = {rem, rad[NPV_RAD_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    ge    = rem_w >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      steps <= 6'(NPV_ROOT_W);
      rad   <= radicand;
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      steps <= steps - 6'd1;
      rad   <= {rad[NPV_RAD_W-3:0], 2'b00};
      rem   <= ge ? (NPV_ROOT_W+2)'(rem_w - trial) : (NPV_ROOT_W+2)'(rem_w);
      root  <= {root[NPV_ROOT_W-2:0], ge};
    end
  end

endmodule

// File: design/nearest_point_velocity_lookup.sv
`timescale 1ns / 1ps
// Nearest-point velocity lookup: a load writes the addressed table entry; a query scans the first
// point_count entries (at most MAX_POINTS) at one table read per cycle, then drains the distance
// pipeline, takes the square root of the smallest sum and reads the nearest entry's velocity.
// One item is worked on at a time; a finished result waits in the output register.
// Synchronous active-high reset clears control state and point_count; the table is not cleared.
// Depends on npv_pkg, npv_store, npv_dist, npv_sqrt and the assertion macro header.
`include "nearest_point_velocity_lookup_macros.svh"
module nearest_point_velocity_lookup import npv_pkg::*; #(
  parameter int MAX_POINTS = NPV_MAX_POINTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [NPV_IDX_W-1:0]         entry_index,
  input  logic signed [NPV_WORD_W-1:0] coord_x,
  input  logic signed [NPV_WORD_W-1:0] coord_z,
  input  logic signed [NPV_WORD_W-1:0] vel_x,
  input  logic signed [NPV_WORD_W-1:0] vel_y,
  input  logic signed [NPV_WORD_W-1:0] vel_z,
  input  logic                         cfg_we,
  input  logic [NPV_CNT_W-1:0]         cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [NPV_IDX_W-1:0]         nearest_index,
  output logic [NPV_DIST_W-1:0]        distance,
  output logic signed [NPV_WORD_W-1:0] near_vel_x,
  output logic signed [NPV_WORD_W-1:0] near_vel_y,
  output logic signed [NPV_WORD_W-1:0] near_vel_z
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  npv_state_t state, state_next;

  logic [NPV_CNT_W-1:0]        point_count;
  logic [CW-1:0]               cnt, cnt_next, n_q, n_eff;
  logic signed [NPV_WORD_W-1:0] qx, qz;
  logic                        accept, load_ok, mem_we, mem_re, rd_vld;
  logic [AW-1:0]               raddr, rd_idx;
  logic [2*NPV_WORD_W-1:0]     rpos;
  logic [3*NPV_WORD_W-1:0]     rvel;
  logic                        d_vld, d_busy;
  logic [AW-1:0]               d_idx;
  logic [NPV_SUM_W-1:0]        d_sum, best_sum;
  logic [AW-1:0]               best_idx;
  logic                        have;
  logic                        sq_start, sq_done;
  logic [NPV_ROOT_W-1:0]       sq_root;
  logic [NPV_ROOT_W-1:0]       root_q;
  logic                        out_free, load_out, load_empty;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign load_ok  = 32'(entry_index) < 32'(MAX_POINTS);
  assign n_eff    = (32'(point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                         : CW'(point_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      rd_vld      <= 1'b0;
      have        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        point_count <= cfg_data;
      end
      rd_vld <= mem_re && (state == S_SCAN);
      if (accept) begin
        have <= 1'b0;
      end else if (d_vld && (!have || d_sum < best_sum)) begin
        have <= 1'b1;
      end
      if (load_out || load_empty) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    rd_idx <= raddr;
    if (accept) begin
      qx  <= coord_x;
      qz  <= coord_z;
      n_q <= n_eff;
    end
    // Strict less-than keeps the lowest index on a tie, since entries arrive in order.
    if (d_vld && (!have || d_sum < best_sum)) begin
      best_sum <= d_sum;
      best_idx <= d_idx;
    end
    if (sq_done) begin
      root_q <= sq_root;
    end
    if (load_out) begin
      found         <= 1'b1;
      nearest_index <= NPV_IDX_W'(best_idx);
      distance      <= NPV_DIST_W'(root_q);
      near_vel_x    <= rvel[NPV_WORD_W-1:0];
      near_vel_y    <= rvel[2*NPV_WORD_W-1:NPV_WORD_W];
      near_vel_z    <= rvel[3*NPV_WORD_W-1:2*NPV_WORD_W];
    end else if (load_empty) begin
      found         <= 1'b0;
      nearest_index <= '0;
      distance      <= '1;
      near_vel_x    <= '0;
      near_vel_y    <= '0;
      near_vel_z    <= '0;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    raddr      = cnt[AW-1:0];
    sq_start   = 1'b0;
    load_out   = 1'b0;
    load_empty = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        if (in_valid) begin
          if (kind == KIND_LOAD) begin
            mem_we = load_ok;
          end else if (n_eff == '0) begin
            state_next = S_EMPTY;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt < n_q) begin
          mem_re   = 1'b1;
          cnt_next = cnt + CW'(1);
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld && !d_busy) begin
          sq_start   = 1'b1;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          state_next = S_VEL;
        end
      end
      S_VEL: begin
        mem_re     = 1'b1;
        raddr      = best_idx;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          load_empty = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  npv_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(entry_index)),
    .wpos  ({coord_z, coord_x}),
    .wvel  ({vel_z, vel_y, vel_x}),
    .re    (mem_re),
    .raddr (raddr),
    .rpos  (rpos),
    .rvel  (rvel)
  );

  npv_dist #(.AW(AW)) u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (rd_vld),
    .in_idx  (rd_idx),
    .qx      (qx),
    .qz      (qz),
    .px      (rpos[NPV_WORD_W-1:0]),
    .pz      (rpos[2*NPV_WORD_W-1:NPV_WORD_W]),
    .out_vld (d_vld),
    .out_idx (d_idx),
    .sum     (d_sum),
    .busy    (d_busy)
  );

  npv_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ({1'b0, best_sum}),
    .done     (sq_done),
    .root     (sq_root)
  );

  `NPV_ASSERT_IMP(a_found_dist, out_valid && found, distance[NPV_DIST_W-1] == 1'b0)
  `NPV_ASSERT_IMP(a_empty_zero, out_valid && !found,
                  nearest_index == '0 && near_vel_x == '0 && near_vel_z == '0)
  `NPV_ASSERT_IMP(a_scan_bound, state == S_SCAN, cnt <= n_q)
  `NPV_ASSERT_IMP(a_root_has_min, state == S_SQRT, have)
  `NPV_ASSERT_NXT(a_scan_leads, state == S_IDLE && accept && kind == KIND_QUERY,
                  state == S_SCAN || state == S_EMPTY)

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for nearest_point_velocity_lookup: a directed table, then random
// load and query beats, each query checked against a local nearest-point predictor or a given result.
// Depends on npv_pkg and the nearest_point_velocity_lookup RTL.
module tb_top;
  import npv_pkg::*;

  typedef struct {
    logic                         kind;
    logic [NPV_IDX_W-1:0]         idx;
    logic signed [NPV_WORD_W-1:0] x, z, vx, vy, vz;
  } item_t;

  typedef struct {
    logic                         found;
    logic [NPV_IDX_W-1:0]         idx;
    logic [NPV_DIST_W-1:0]        root_dist;
    logic signed [NPV_WORD_W-1:0] vx, vy, vz;
  } lookup_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_op_t;

  typedef struct {
    row_op_t                op;
    item_t                  it;
    logic [NPV_CNT_W-1:0]   count;
    bit                     typed;
    lookup_t                want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [NPV_IDX_W-1:0] entry_index;
  logic signed [NPV_WORD_W-1:0] coord_x, coord_z, vel_x, vel_y, vel_z;
  logic cfg_we;
  logic [NPV_CNT_W-1:0] cfg_data;
  logic found;
  logic [NPV_IDX_W-1:0] nearest_index;
  logic [NPV_DIST_W-1:0] distance;
  logic signed [NPV_WORD_W-1:0] near_vel_x, near_vel_y, near_vel_z;

  // Shadow copy of the point table and the search count.
  logic [NPV_WORD_W-1:0] tab_x [NPV_MAX_POINTS];
  logic [NPV_WORD_W-1:0] tab_z [NPV_MAX_POINTS];
  logic [NPV_WORD_W-1:0] tab_vx [NPV_MAX_POINTS];
  logic [NPV_WORD_W-1:0] tab_vy [NPV_MAX_POINTS];
  logic [NPV_WORD_W-1:0] tab_vz [NPV_MAX_POINTS];
  logic [NPV_CNT_W-1:0]  search_count;

  lookup_t pending_lookups[$];
  row_t    rows[$];
  int      error_count = 0;
  bit      idle_on = 1'b1;
  int      hold_seq = 0;
  int      hold_seen = 0;
  int      hold_cnt = 0;

  nearest_point_velocity_lookup u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .entry_index(entry_index),
    .coord_x(coord_x), .coord_z(coord_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .nearest_index(nearest_index), .distance(distance),
    .near_vel_x(near_vel_x), .near_vel_y(near_vel_y), .near_vel_z(near_vel_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #80ms;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [NPV_ROOT_W-1:0] floor_root(logic [NPV_RAD_W-1:0] v);
    logic [NPV_ROOT_W-1:0] r;
    logic [NPV_RAD_W-1:0]  c;
    r = '0;
    for (int b = NPV_ROOT_W - 1; b >= 0; b--) begin
      c = {33'd0, r | (33'd1 << b)};
      if (c * c <= v) r = r | (33'd1 << b);
    end
    return r;
  endfunction

  function automatic logic [NPV_RAD_W-1:0] planar_sq(logic [31:0] ax, logic [31:0] az,
                                                     logic [31:0] bx, logic [31:0] bz);
    logic signed [32:0]    dx, dz;
    logic [NPV_RAD_W-1:0]  mx, mz;
    dx = $signed({ax[31], ax}) - $signed({bx[31], bx});
    dz = $signed({az[31], az}) - $signed({bz[31], bz});
    mx = {33'd0, dx < 0 ? 33'(-dx) : 33'(dx)};
    mz = {33'd0, dz < 0 ? 33'(-dz) : 33'(dz)};
    return mx * mx + mz * mz;
  endfunction

  function automatic lookup_t nearest_lookup(logic [31:0] qx, logic [31:0] qz);
    lookup_t              res;
    int                   n;
    logic [NPV_RAD_W-1:0] best, d;
    n = search_count > NPV_MAX_POINTS ? NPV_MAX_POINTS : int'(search_count);
    res = '{found: 1'b0, idx: '0, root_dist: '1, vx: '0, vy: '0, vz: '0};
    best = '0;
    for (int i = 0; i < n; i++) begin
      d = planar_sq(qx, qz, tab_x[i], tab_z[i]);
      if (!res.found || d < best) begin
        res.found = 1'b1;
        res.idx = NPV_IDX_W'(i);
        best = d;
      end
    end
    if (res.found) begin
      res.root_dist = {1'b0, floor_root(best)};
      res.vx = tab_vx[res.idx];
      res.vy = tab_vy[res.idx];
      res.vz = tab_vz[res.idx];
    end
    return res;
  endfunction

  // Drives one beat and holds it until accepted; on acceptance the shadow table is
  // updated or the expected lookup is queued.
  task automatic send_item(item_t it, bit typed, lookup_t want);
    int gap;
    in_valid <= 1'b1;
    kind <= it.kind;
    entry_index <= it.idx;
    coord_x <= it.x;
    coord_z <= it.z;
    vel_x <= it.vx;
    vel_y <= it.vy;
    vel_z <= it.vz;
    do @(posedge clk); while (!in_ready);
    if (it.kind == KIND_LOAD) begin
      tab_x[it.idx] = it.x;
      tab_z[it.idx] = it.z;
      tab_vx[it.idx] = it.vx;
      tab_vy[it.idx] = it.vy;
      tab_vz[it.idx] = it.vz;
    end else begin
      pending_lookups.push_back(typed ? want : nearest_lookup(it.x, it.z));
    end
    gap = (idle_on && $urandom_range(99) < 18) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_count(logic [NPV_CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    search_count = v;
  endtask

  function automatic logic [31:0] pick_coord(bit near_table);
    logic [31:0] c;
    case ($urandom_range(3))
      0: c = $urandom;
      1: c = 32'($signed($urandom_range(2047)) - 1024) <<< $urandom_range(16);
      default: c = near_table ? tab_x[$urandom_range(31)] + $urandom_range(3) : $urandom;
    endcase
    return c;
  endfunction

  function automatic item_t rand_item(bit is_query);
    item_t it;
    int    lim;
    lim = search_count == 0 ? 31 : (search_count > 1023 ? 1023 : int'(search_count) - 1);
    it.kind = is_query ? KIND_QUERY : KIND_LOAD;
    it.idx = $urandom_range(3) == 0 ? NPV_IDX_W'($urandom) : NPV_IDX_W'($urandom_range(lim));
    it.x = pick_coord(1'b1);
    it.z = $urandom_range(2) == 0 ? pick_coord(1'b0) : tab_z[it.idx];
    it.vx = $urandom;
    it.vy = $urandom;
    it.vz = $urandom;
    return it;
  endfunction

  function automatic item_t mk(logic k, int i, logic [31:0] x, logic [31:0] z,
                               logic [31:0] a, logic [31:0] b, logic [31:0] c);
    item_t it;
    it = '{kind: k, idx: NPV_IDX_W'(i), x: x, z: z, vx: a, vy: b, vz: c};
    return it;
  endfunction

  task automatic add_row(row_op_t op, item_t it, int count);
    row_t r;
    r.op = op;
    r.it = it;
    r.count = NPV_CNT_W'(count);
    r.typed = 1'b0;
    r.want = '{found: 1'b0, idx: '0, root_dist: '1, vx: '0, vy: '0, vz: '0};
    rows.push_back(r);
  endtask

  task automatic add_typed(item_t it, lookup_t want);
    row_t r;
    r.op = ROW_QUERY;
    r.it = it;
    r.count = '0;
    r.typed = 1'b1;
    r.want = want;
    rows.push_back(r);
  endtask

  task automatic build_rows();
    lookup_t none;
    item_t   nil;
    none = '{found: 1'b0, idx: '0, root_dist: '1, vx: '0, vy: '0, vz: '0};
    nil = mk(KIND_QUERY, 0, 0, 0, 0, 0, 0);
    // An empty search straight after reset.
    add_typed(mk(KIND_QUERY, 1023, 32'h8000_0000, 32'h7fff_ffff, '1, '1, '1), none);
    // Extreme entries at the ends of the table.
    add_row(ROW_LOAD, mk(KIND_LOAD, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h8000_0000, '1), 0);
    add_row(ROW_LOAD, mk(KIND_LOAD, 1, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h7fff_ffff, 0), 0);
    add_row(ROW_LOAD, mk(KIND_LOAD, 1023, 0, 0, '1, 0, '1), 0);
    add_row(ROW_COUNT, nil, 1);
    add_typed(mk(KIND_QUERY, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0),
              '{found: 1'b1, idx: '0, root_dist: '0, vx: 32'h7fff_ffff,
                vy: 32'h8000_0000, vz: '1});
    // Opposite corners give the largest possible distance.
    add_row(ROW_QUERY, mk(KIND_QUERY, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0), 0);
    add_row(ROW_COUNT, nil, 2);
    add_row(ROW_QUERY, mk(KIND_QUERY, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0), 0);
    // Equal distances either side: the lower index must win.
    add_row(ROW_LOAD, mk(KIND_LOAD, 0, 32'h0001_0000, 0, 11, 12, 13), 0);
    add_row(ROW_LOAD, mk(KIND_LOAD, 1, 32'hffff_0000, 0, 21, 22, 23), 0);
    add_typed(mk(KIND_QUERY, 0, 0, 0, 0, 0, 0),
              '{found: 1'b1, idx: '0, root_dist: 34'h1_0000, vx: 11, vy: 12, vz: 13});
    // A distance squared of two must round down to one.
    add_row(ROW_QUERY, mk(KIND_QUERY, 0, 32'h0001_0001, 1, 0, 0, 0), 0);
    // Counts past the table end saturate to a full scan.
    add_row(ROW_COUNT, nil, 2047);
    add_row(ROW_QUERY, mk(KIND_QUERY, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0), 0);
    add_row(ROW_COUNT, nil, 1024);
    add_row(ROW_QUERY, mk(KIND_QUERY, 0, 0, 1, 0, 0, 0), 0);
    add_row(ROW_COUNT, nil, 1025);
    add_row(ROW_QUERY, mk(KIND_QUERY, 0, 32'h0000_ffff, 32'hffff_ffff, 0, 0, 0), 0);
    add_row(ROW_COUNT, nil, 0);
    add_typed(mk(KIND_QUERY, 0, 5, 5, 0, 0, 0), none);
  endtask

  // Result side: random stalls, with one long hold-off.
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    lookup_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        $error("result beat with no query outstanding");
        error_count++;
      end else begin
        w = pending_lookups.pop_front();
        if (found !== w.found) begin
          $error("found: expected %0d, got %0d", w.found, found);
          error_count++;
        end
        if (nearest_index !== w.idx) begin
          $error("nearest_index: expected %0d, got %0d", w.idx, nearest_index);
          error_count++;
        end
        if (distance !== w.root_dist) begin
          $error("distance: expected %h, got %h", w.root_dist, distance);
          error_count++;
        end
        if (near_vel_x !== w.vx) begin
          $error("near_vel_x: expected %h, got %h", w.vx, near_vel_x);
          error_count++;
        end
        if (near_vel_y !== w.vy) begin
          $error("near_vel_y: expected %h, got %h", w.vy, near_vel_y);
          error_count++;
        end
        if (near_vel_z !== w.vz) begin
          $error("near_vel_z: expected %h, got %h", w.vz, near_vel_z);
          error_count++;
        end
      end
    end
  end

  initial begin
    lookup_t dummy;
    item_t   it;
    int      pick;
    dummy = '{found: 1'b0, idx: '0, root_dist: '1, vx: '0, vy: '0, vz: '0};
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_LOAD;
    entry_index <= '0;
    coord_x <= '0;
    coord_z <= '0;
    vel_x <= '0;
    vel_y <= '0;
    vel_z <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    search_count = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_rows();
    foreach (rows[i]) begin
      if (rows[i].op == ROW_COUNT) set_count(rows[i].count);
      else send_item(rows[i].it, rows[i].typed, rows[i].want);
      // Fill the whole table before any search reaches beyond the loaded entries.
      if (i == 3) begin
        for (int e = 2; e < NPV_MAX_POINTS - 1; e++)
          send_item(mk(KIND_LOAD, e, $urandom, $urandom, $urandom, $urandom, $urandom),
                    1'b0, dummy);
      end
    end

    for (int n = 0; n < 570; n++) begin
      if (n % 60 == 0) begin
        pick = $urandom_range(9);
        if (pick == 0) set_count(0);
        else if (pick == 1) set_count(NPV_CNT_W'($urandom_range(1024, 2047)));
        else set_count(NPV_CNT_W'($urandom_range(1, 32)));
      end
      idle_on = !(n >= 250 && n < 350);
      if (n == 150) hold_seq++;
      it = rand_item($urandom_range(1));
      send_item(it, 1'b0, dummy);
    end
    in_valid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
